// ===== hdl/mask_morph_grow_shrink_unit_macros.svh =====
// Assertion macros for the mask morphology unit
`ifndef MASK_MORPH_GROW_SHRINK_UNIT_MACROS_SVH
`define MASK_MORPH_GROW_SHRINK_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MMGS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MMGS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MMGS_ASSERT_IMP(lbl, ante, cons)
`define MMGS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/mmgs_pkg.sv =====
`timescale 1ns / 1ps

package mmgs_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_RADIUS = 15;

	localparam int X_W      = 8;
	localparam int Y_W      = 8;
	localparam int PIX_W    = 8;
	localparam int DIM_W    = 9;
	localparam int RADCFG_W = 5;
	localparam int CFG_W    = 9;
	localparam int CFG_IDX_W = 2;

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam int MAG_W = $clog2(MAX_RADIUS + 1);
	localparam int OFF_W = MAG_W + 1;
	localparam int SQ_W  = 2 * MAG_W + 1;
	localparam int SC_W  = ((X_W > Y_W) ? X_W : Y_W) + 2;

	localparam logic [PIX_W-1:0] PIX_MAX = '1;
	localparam logic [PIX_W-1:0] PIX_MIN = '0;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GROW_RADIUS  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  data;
	} wr_req_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} rd_req_t;

endpackage

// ===== hdl/mask_morph_grow_shrink_unit.sv =====
// channel | dir | fields (low bit up)                        | request when
// s       | in  | tdata: pos_x, pos_y, pixel_value; tuser: mode | s_tvalid & s_tready
// m       | out | tdata: result_value, result_x, result_y      | m_tvalid & m_tready
// cfg     | in  | index, data                                  | cfg_valid & cfg_ready
//
// Query inside the frame: scans every offset of the square of side 2m+1,
// m = min(|radius|, 15), one offset a cycle through the single frame-store
// read port. Query outside the frame skips the scan.
// Reset sets width 256, height 256, radius 0; store contents undefined, no clearing pass.
// s_tready drops from a query request until its result enters the output register;
// a held result stalls only the next finished query.
`timescale 1ns / 1ps
`include "mask_morph_grow_shrink_unit_macros.svh"

module mask_morph_grow_shrink_unit
	import mmgs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // pos_x, pos_y, pixel_value
	input  logic                 s_tuser,   // mode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // result_value, result_x, result_y
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	state_t state_q, state_nxt;

	logic [DIM_W-1:0]           frame_width_q, frame_height_q;
	logic signed [RADCFG_W-1:0] grow_radius_q;
	logic [DIM_W-1:0]           act_w, act_h;

	logic [X_W-1:0]   in_x;
	logic [Y_W-1:0]   in_y;
	logic [PIX_W-1:0] in_pix;
	logic             in_inside, in_req, start;

	logic [RADCFG_W-1:0] r_neg, r_raw;
	logic [MAG_W-1:0]    r_mag;
	logic                r_erode;

	logic [X_W-1:0]          x_q;
	logic [Y_W-1:0]          y_q;
	logic [MAG_W-1:0]        mag_q;
	logic                    erode_q;
	logic signed [OFF_W-1:0] dx_q, dy_q, mag_s;
	logic [PIX_W-1:0]        acc_q;

	logic signed [SC_W-1:0] sx, sy;
	logic signed [SQ_W:0]   sq_dx, sq_dy, sq_mag;
	logic                   in_disk, in_frame, last_pt, scan_issue;
	logic                   rd_s1, zero_s1;

	logic             out_load, out_valid_q;
	logic [PIX_W-1:0] out_value_q;
	logic [X_W-1:0]   out_x_q;
	logic [Y_W-1:0]   out_y_q;

	wr_req_t          wr;
	rd_req_t          rd;
	logic [PIX_W-1:0] rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= DIM_W'(256);
			frame_height_q <= DIM_W'(256);
			grow_radius_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[DIM_W-1:0];
				REG_GROW_RADIUS:  grow_radius_q  <= $signed(cfg_data[RADCFG_W-1:0]);
				default: ;
			endcase
		end
	end

	assign act_w = (frame_width_q  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : frame_width_q;
	assign act_h = (frame_height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : frame_height_q;

	assign in_x   = s_tdata[7:0];
	assign in_y   = s_tdata[15:8];
	assign in_pix = s_tdata[23:16];
	assign in_inside = (DIM_W'(in_x) < act_w) && (DIM_W'(in_y) < act_h);
	assign in_req = s_tvalid && s_tready;
	assign start  = in_req && (s_tuser == MODE_QUERY);

	// radius magnitude, -16 included, saturates
	assign r_neg   = RADCFG_W'(-grow_radius_q);
	assign r_erode = grow_radius_q[RADCFG_W-1];
	assign r_raw   = r_erode ? r_neg : grow_radius_q;
	assign r_mag   = (r_raw > RADCFG_W'(MAX_RADIUS)) ? MAG_W'(MAX_RADIUS) : MAG_W'(r_raw);

	assign mag_s  = $signed({1'b0, mag_q});
	assign sx     = $signed(SC_W'(x_q)) + SC_W'(dx_q);
	assign sy     = $signed(SC_W'(y_q)) + SC_W'(dy_q);
	assign sq_dx  = dx_q * dx_q;
	assign sq_dy  = dy_q * dy_q;
	assign sq_mag = mag_s * mag_s;
	assign in_disk  = (sq_dx + sq_dy) <= sq_mag;
	assign in_frame = (sx >= 0) && (sx < $signed(SC_W'(act_w)))
		&& (sy >= 0) && (sy < $signed(SC_W'(act_h)));
	assign last_pt = (dx_q == mag_s) && (dy_q == mag_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		s_tready   = 1'b0;
		scan_issue = 1'b0;
		out_load   = 1'b0;
		wr.en      = 1'b0;
		wr.addr    = ADDR_W'(in_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_x);
		wr.data    = in_pix;
		rd.en      = 1'b0;
		rd.addr    = ADDR_W'(sy[Y_W-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sx[X_W-1:0]);
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (in_req) begin
					if (s_tuser == MODE_LOAD) begin
						wr.en = in_inside;
					end else begin
						state_nxt = in_inside ? ST_SCAN : ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				scan_issue = 1'b1;
				rd.en = in_disk && in_frame;
				if (last_pt) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q     <= in_x;
			y_q     <= in_y;
			mag_q   <= r_mag;
			erode_q <= r_erode;
			dx_q    <= -$signed({1'b0, r_mag});
			dy_q    <= -$signed({1'b0, r_mag});
		end else if (scan_issue) begin
			if (dx_q == mag_s) begin
				dx_q <= -mag_s;
				dy_q <= dy_q + OFF_W'(1);
			end else begin
				dx_q <= dx_q + OFF_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1   <= 1'b0;
			zero_s1 <= 1'b0;
		end else begin
			rd_s1   <= scan_issue && in_disk && in_frame;
			zero_s1 <= scan_issue && in_disk && !in_frame && erode_q;
		end
	end

	// a disk point off the frame pins an erosion at zero
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= (in_inside && r_erode) ? PIX_MAX : PIX_MIN;
		end else if (zero_s1) begin
			acc_q <= PIX_MIN;
		end else if (rd_s1) begin
			if (erode_q) begin
				acc_q <= (rd_data < acc_q) ? rd_data : acc_q;
			end else begin
				acc_q <= (rd_data > acc_q) ? rd_data : acc_q;
			end
		end
	end

	mmgs_frame_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= acc_q;
			out_x_q     <= x_q;
			out_y_q     <= y_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_y_q, out_x_q, out_value_q};

	`MMGS_ASSERT_IMP(a_no_write_busy, state_q != ST_IDLE, !wr.en)
	`MMGS_ASSERT_IMP(a_scan_range, state_q == ST_SCAN, (dx_q <= mag_s) && (dy_q <= mag_s) && (dx_q >= -mag_s) && (dy_q >= -mag_s))
	`MMGS_ASSERT_NEXT(a_done_holds, (state_q == ST_DONE) && out_valid_q && !m_tready, state_q == ST_DONE)
	`MMGS_ASSERT_IMP(a_one_flag, rd_s1 || zero_s1, state_q == ST_SCAN || state_q == ST_DRAIN)

endmodule

// ===== hdl/mmgs_frame_store.sv =====
`timescale 1ns / 1ps

module mmgs_frame_store
	import mmgs_pkg::*;
(
	input  logic             clk,
	input  wr_req_t          wr,
	input  rd_req_t          rd,
	output logic [PIX_W-1:0] rd_data
);

	logic [PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

// ===== dv/tb_mask_morph_grow_shrink_unit.sv =====
`timescale 1ns / 1ps

module tb_mask_morph_grow_shrink_unit;
	import mmgs_pkg::*;

	localparam int WATCHDOG_LIMIT = 10000;
	localparam int SETTLE_CYCLES  = 16;

	typedef struct {
		bit [PIX_W-1:0] value;
		bit [X_W-1:0]   x;
		bit [Y_W-1:0]   y;
	} morph_result_t;

	class morph_tracker;
		bit [PIX_W-1:0] pix_mem [DEPTH];
		bit written [DEPTH];
		bit [DIM_W-1:0] width_reg;
		bit [DIM_W-1:0] height_reg;
		bit signed [RADCFG_W-1:0] radius_reg;
		morph_result_t awaited_results [$];
		int errors;

		function new();
			width_reg  = DIM_W'(MAX_WIDTH);
			height_reg = DIM_W'(MAX_HEIGHT);
			radius_reg = '0;
			errors     = 0;
		endfunction

		function int act_w();
			return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
		endfunction

		function int act_h();
			return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_FRAME_WIDTH:  width_reg  = data[DIM_W-1:0];
				REG_FRAME_HEIGHT: height_reg = data[DIM_W-1:0];
				REG_GROW_RADIUS:  radius_reg = data[RADCFG_W-1:0];
				default: ;
			endcase
		endfunction

		// ready is cleared when the query would read a store entry never loaded
		function int morph_value(int x, int y, output bit ready);
			int aw = act_w();
			int ah = act_h();
			int r = radius_reg;
			bit erode = (r < 0);
			int m;
			int acc;
			int sx;
			int sy;
			int a;
			ready = 1'b1;
			m = erode ? -r : r;
			if (m > MAX_RADIUS)
				m = MAX_RADIUS;
			if (x >= aw || y >= ah)
				return 0;
			if (m == 0) begin
				a = y * MAX_WIDTH + x;
				ready = written[a];
				return pix_mem[a];
			end
			acc = erode ? PIX_MAX : PIX_MIN;
			for (int dy = -m; dy <= m; dy++) begin
				for (int dx = -m; dx <= m; dx++) begin
					sx = x + dx;
					sy = y + dy;
					if (dx * dx + dy * dy <= m * m) begin
						if (sx >= 0 && sx < aw && sy >= 0 && sy < ah) begin
							a = sy * MAX_WIDTH + sx;
							if (!written[a])
								ready = 1'b0;
							if (erode ? (pix_mem[a] < acc) : (pix_mem[a] > acc))
								acc = pix_mem[a];
						end else if (erode) begin
							acc = 0;
						end
					end
				end
			end
			return acc;
		endfunction

		function void note_request(logic mode, logic [X_W-1:0] x, logic [Y_W-1:0] y,
				logic [PIX_W-1:0] v);
			int xi = x;
			int yi = y;
			bit ok;
			morph_result_t e;
			if (mode == MODE_LOAD) begin
				if (xi < act_w() && yi < act_h()) begin
					pix_mem[yi * MAX_WIDTH + xi] = v;
					written[yi * MAX_WIDTH + xi] = 1'b1;
				end
			end else begin
				e.value = PIX_W'(morph_value(xi, yi, ok));
				e.x = x;
				e.y = y;
				awaited_results.push_back(e);
			end
		endfunction

		function void check_result(logic [23:0] d);
			morph_result_t e;
			if (awaited_results.size() == 0) begin
				$error("result with no query waiting: %h", d);
				errors++;
				return;
			end
			e = awaited_results.pop_front();
			if (d[7:0] !== e.value) begin
				$error("result_value: expected %0d, got %0d", e.value, d[7:0]);
				errors++;
			end
			if (d[15:8] !== e.x) begin
				$error("result_x: expected %0d, got %0d", e.x, d[15:8]);
				errors++;
			end
			if (d[23:16] !== e.y) begin
				$error("result_y: expected %0d, got %0d", e.y, d[23:16]);
				errors++;
			end
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [23:0]          s_tdata = '0;   // pos_x, pos_y, pixel_value
	logic                 s_tuser = 1'b0; // mode
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [23:0]          m_tdata;        // result_value, result_x, result_y
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	morph_tracker mt = new();
	bit quiet = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;

	mask_morph_grow_shrink_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [PIX_W-1:0] rand_pix();
		int r = $urandom_range(0, 7);
		if (r == 0)
			return PIX_MIN;
		if (r == 1)
			return PIX_MAX;
		return PIX_W'($urandom);
	endfunction

	// a query is only legal once every store entry it reads has been loaded
	function automatic bit pick_query(output logic [X_W-1:0] qx, output logic [Y_W-1:0] qy);
		int aw = mt.act_w();
		int ah = mt.act_h();
		int sw;
		int sh;
		bit ok;
		sw = (aw < 24) ? aw : 24;
		sh = (ah < 24) ? ah : 24;
		for (int i = 0; i < 12; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				qx = X_W'($urandom);
				qy = Y_W'($urandom);
			end else begin
				qx = X_W'($urandom_range(0, sw));
				qy = Y_W'($urandom_range(0, sh));
			end
			void'(mt.morph_value(qx, qy, ok));
			if (ok)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			mt.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_mask_morph_grow_shrink_unit: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(input logic mode, input logic [X_W-1:0] x,
			input logic [Y_W-1:0] y, input logic [PIX_W-1:0] v);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {v, y, x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		mt.note_request(mode, x, y, v);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		mt.set_reg(idx, data);
	endtask

	task automatic settle();
		while (mt.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input int w, input int h, input logic [RADCFG_W-1:0] r);
		settle();
		write_reg(REG_FRAME_WIDTH, CFG_W'(w));
		write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
		write_reg(REG_GROW_RADIUS, CFG_W'(r));
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int w, input int h, input logic [RADCFG_W-1:0] r,
			input int n);
		int aw;
		int ah;
		int sw;
		int sh;
		int counted;
		int tries;
		logic [X_W-1:0] px;
		logic [Y_W-1:0] py;
		configure(w, h, r);
		quiet = ($urandom_range(0, 3) == 0);
		aw = mt.act_w();
		ah = mt.act_h();
		sw = (aw < 24) ? aw : 24;
		sh = (ah < 24) ? ah : 24;
		if (aw * ah <= 150) begin
			for (int yy = 0; yy < ah; yy++)
				for (int xx = 0; xx < aw; xx++)
					if (!mt.written[yy * MAX_WIDTH + xx])
						send_item(MODE_LOAD, X_W'(xx), Y_W'(yy), rand_pix());
		end
		counted = 0;
		tries = 0;
		while (counted < n && tries < 4 * n) begin
			tries++;
			if ($urandom_range(0, 99) < 45 && pick_query(px, py)) begin
				send_item(MODE_QUERY, px, py, PIX_W'($urandom));
				counted++;
			end else if (aw == 0 || ah == 0 || $urandom_range(0, 4) == 0) begin
				px = X_W'($urandom);
				py = Y_W'($urandom);
				if (px < aw && py < ah)
					counted++;
				send_item(MODE_LOAD, px, py, rand_pix());
			end else begin
				if ($urandom_range(0, 4) == 0) begin
					px = X_W'($urandom_range(0, aw - 1));
					py = Y_W'($urandom_range(0, ah - 1));
				end else begin
					px = X_W'($urandom_range(0, sw - 1));
					py = Y_W'($urandom_range(0, sh - 1));
				end
				counted++;
				send_item(MODE_LOAD, px, py, rand_pix());
			end
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin
		logic [PIX_W-1:0] seed_vals [12];
		seed_vals = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE,
			8'h55, 8'hAA, 8'h10, 8'hEF, 8'h33, 8'hCC};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		configure(4, 3, 5'd0);
		for (int yy = 0; yy < 3; yy++)
			for (int xx = 0; xx < 4; xx++)
				send_item(MODE_LOAD, X_W'(xx), Y_W'(yy), seed_vals[yy * 4 + xx]);
		send_item(MODE_LOAD, 8'd255, 8'd255, 8'hFF);
		send_item(MODE_LOAD, 8'd4, 8'd0, 8'h99);
		send_item(MODE_QUERY, 8'd0, 8'd0, 8'h00);
		send_item(MODE_QUERY, 8'd3, 8'd2, 8'hFF);
		send_item(MODE_QUERY, 8'd255, 8'd255, 8'h00);
		send_item(MODE_QUERY, 8'd0, 8'd3, 8'h00);
		s_tvalid <= 1'b0;

		configure(4, 3, 5'd1);
		send_item(MODE_QUERY, 8'd1, 8'd1, 8'h00);
		send_item(MODE_QUERY, 8'd3, 8'd0, 8'h00);
		s_tvalid <= 1'b0;

		// erosion: interior point, then a corner whose disk leaves the frame
		configure(4, 3, 5'h1F);
		send_item(MODE_QUERY, 8'd1, 8'd1, 8'h00);
		send_item(MODE_QUERY, 8'd0, 8'd0, 8'h00);
		s_tvalid <= 1'b0;

		// empty frame
		configure(0, 3, 5'd0);
		send_item(MODE_LOAD, 8'd0, 8'd0, 8'h07);
		send_item(MODE_QUERY, 8'd0, 8'd0, 8'h00);
		s_tvalid <= 1'b0;

		run_random(6, 5, 5'd1, 40);
		run_random(6, 5, 5'h1E, 35);
		run_random(1, 1, 5'd15, 15);
		run_random(1, 1, 5'h10, 15);
		run_random(16, 4, 5'h1F, 40);
		run_random(7, 9, 5'd3, 40);
		run_random(0, 5, 5'd2, 15);
		run_random(5, 0, 5'h1D, 15);
		run_random(256, 256, 5'd0, 50);
		run_random(511, 300, 5'd2, 45);
		run_random(300, 511, 5'h1E, 45);
		run_random(12, 12, 5'h11, 20);
		for (int i = 0; i < 4; i++)
			run_random($urandom_range(1, 14), $urandom_range(1, 10),
				RADCFG_W'($urandom_range(0, 31)), 10);

		quiet = 1'b0;
		settle();
		if (mt.errors == 0)
			$display("tb_mask_morph_grow_shrink_unit: PASS");
		else
			$display("tb_mask_morph_grow_shrink_unit: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mmgs_pkg.sv
hdl/mmgs_frame_store.sv
hdl/mask_morph_grow_shrink_unit.sv
dv/tb_mask_morph_grow_shrink_unit.sv
